// ===== sv/sirc_frame_decoder_top_defines.svh =====
// Assertion macros for the checker file of the SIRC frame decoder.
`ifndef SIRC_FRAME_DECODER_TOP_DEFINES_SVH
`define SIRC_FRAME_DECODER_TOP_DEFINES_SVH

// Checked at every clock edge outside reset.
`define SFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/sfd_pkg.sv =====
package sfd_pkg;

  localparam int DurBits    = 15;
  localparam int CountBits  = 5;
  localparam int ShiftBits  = 20;
  localparam int CfgIdxBits = 3;

  localparam logic [CountBits-1:0] CountMax = 5'd31;
  localparam logic [CountBits-1:0] NoneBad  = 5'd31;

  typedef enum logic [CfgIdxBits-1:0] {
    RegStartMark  = 3'd0,
    RegStartSpace = 3'd1,
    RegOneMark    = 3'd2,
    RegZeroMark   = 3'd3,
    RegBitSpace   = 3'd4,
    RegTolerance  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [DurBits-1:0] mark_ticks;
    logic [DurBits-1:0] space_ticks;
    logic               last_pair;
  } pair_t;

  typedef struct packed {
    logic        frame_ok;
    logic [6:0]  command_code;
    logic [12:0] device_address;
    logic [4:0]  frame_bits;
    logic [19:0] wire_raw;
  } result_t;

  // Outcome of the duration compares for one pulse pair.
  typedef struct packed {
    logic start_ok;
    logic mark_one;
    logic mark_zero;
    logic space_ok;
    logic last_pair;
  } pair_class_t;

  // Queue handshake on the write side, between the input and the class queue.
  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

endpackage

// ===== sv/sirc_frame_decoder_top.sv =====
// A last pair passes the class queue and then the result register before its result beat is offered.
// Throughput: one pulse pair per cycle. While a result beat waits in the output register,
// pairs of the next frame keep draining; only that frame's last pair waits for it, and the
// two-entry class queue then fills behind it before the input stalls.
// Reset (rst, synchronous, active high): timing registers return to their defaults,
// the queue and the frame state empty, and no result beat is offered.
module sirc_frame_decoder_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sfd_pkg::CfgIdxBits-1:0] cfg_index,
  input  logic [sfd_pkg::DurBits-1:0]    cfg_data,
  input  logic                           pair_valid,
  output logic                           pair_stall,
  input  sfd_pkg::pair_t                 pair_data,
  output logic                           result_valid,
  input  logic                           result_stall,
  output sfd_pkg::result_t               result_data
);

  // The front compares each pair's mark and space against the programmed
  // targets; it needs no frame state, so it never waits on the back.
  sfd_pkg::pair_class_t pair_class;
  sfd_pkg::pair_class_t head_data;
  sfd_pkg::q_wr_t       q_wr;
  logic                 head_valid;
  logic                 pop;

  sfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pair_data  (pair_data),
    .pair_class (pair_class)
  );

  // The input beat is taken whenever the queue has room; the stall is a
  // registered full flag, so it has no path from the output side.
  assign q_wr.push  = pair_valid && !pair_stall;
  assign pair_stall = q_wr.full;

  sfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_wr.push),
    .push_data  (pair_class),
    .full       (q_wr.full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // The back keeps the frame state (pair count, start flag, collected bits and
  // the first bad bit) and builds the result on the last pair of a frame.
  sfd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_data    (head_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule

// ===== sv/sfd_queue.sv =====
module sfd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sfd_pkg::pair_class_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output sfd_pkg::pair_class_t head_data
);

  sfd_pkg::pair_class_t slots [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       do_push;
  logic       do_pop;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_data  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== sv/sfd_front.sv =====
module sfd_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sfd_pkg::CfgIdxBits-1:0]    cfg_index,
  input  logic [sfd_pkg::DurBits-1:0]       cfg_data,
  input  sfd_pkg::pair_t                    pair_data,
  output sfd_pkg::pair_class_t              pair_class
);

  logic [sfd_pkg::DurBits-1:0] start_mark_ticks;
  logic [sfd_pkg::DurBits-1:0] start_space_ticks;
  logic [sfd_pkg::DurBits-1:0] one_mark_ticks;
  logic [sfd_pkg::DurBits-1:0] zero_mark_ticks;
  logic [sfd_pkg::DurBits-1:0] bit_space_ticks;
  logic [sfd_pkg::DurBits-1:0] match_tolerance;

  // True when the duration lies within the tolerance of the target.
  function automatic logic near(input logic [sfd_pkg::DurBits-1:0] d,
                                input logic [sfd_pkg::DurBits-1:0] t,
                                input logic [sfd_pkg::DurBits-1:0] tol);
    logic [sfd_pkg::DurBits-1:0] diff;
    diff = (d > t) ? (d - t) : (t - d);
    return diff <= tol;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      start_mark_ticks  <= sfd_pkg::DurBits'(2400);
      start_space_ticks <= sfd_pkg::DurBits'(600);
      one_mark_ticks    <= sfd_pkg::DurBits'(1200);
      zero_mark_ticks   <= sfd_pkg::DurBits'(600);
      bit_space_ticks   <= sfd_pkg::DurBits'(600);
      match_tolerance   <= sfd_pkg::DurBits'(200);
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfd_pkg::RegStartMark:  start_mark_ticks  <= cfg_data;
        sfd_pkg::RegStartSpace: start_space_ticks <= cfg_data;
        sfd_pkg::RegOneMark:    one_mark_ticks    <= cfg_data;
        sfd_pkg::RegZeroMark:   zero_mark_ticks   <= cfg_data;
        sfd_pkg::RegBitSpace:   bit_space_ticks   <= cfg_data;
        sfd_pkg::RegTolerance:  match_tolerance   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    pair_class.start_ok  = near(pair_data.mark_ticks, start_mark_ticks, match_tolerance)
                        && near(pair_data.space_ticks, start_space_ticks, match_tolerance);
    pair_class.mark_one  = near(pair_data.mark_ticks, one_mark_ticks, match_tolerance);
    pair_class.mark_zero = near(pair_data.mark_ticks, zero_mark_ticks, match_tolerance);
    pair_class.space_ok  = near(pair_data.space_ticks, bit_space_ticks, match_tolerance);
    pair_class.last_pair = pair_data.last_pair;
  end

endmodule

// ===== sv/sfd_back.sv =====
module sfd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  sfd_pkg::pair_class_t head_data,
  output logic                 pop,
  output logic                 result_valid,
  input  logic                 result_stall,
  output sfd_pkg::result_t     result_data
);

  logic [sfd_pkg::CountBits-1:0] pairs_seen;
  logic                          start_matched;
  logic [sfd_pkg::ShiftBits-1:0] bit_shift;
  logic [sfd_pkg::CountBits-1:0] first_bad_bit;

  logic [sfd_pkg::CountBits-1:0] pairs_seen_next;
  logic                          start_matched_next;
  logic [sfd_pkg::ShiftBits-1:0] bit_shift_next;
  logic [sfd_pkg::CountBits-1:0] first_bad_bit_next;
  logic [sfd_pkg::CountBits-1:0] data_pairs;
  logic [sfd_pkg::CountBits-1:0] bit_pos;
  logic                          good;
  logic                          ok;
  logic [4:0]                    bits;
  logic [12:0]                   addr;
  logic [6:0]                    cmd;
  logic [19:0]                   logical;
  logic [19:0]                   raw;
  sfd_pkg::result_t              result_next;

  // A non-last record never needs the result register, so it always drains.
  assign pop = head_valid
            && (!head_data.last_pair || !result_valid || !result_stall);

  always_comb begin
    pairs_seen_next    = (pairs_seen < sfd_pkg::CountMax) ? pairs_seen + 5'd1 : pairs_seen;
    start_matched_next = start_matched;
    bit_shift_next     = bit_shift;
    first_bad_bit_next = first_bad_bit;
    bit_pos            = pairs_seen - 5'd1;
    good = (head_data.mark_one || head_data.mark_zero)
        && (head_data.last_pair || head_data.space_ok);

    if (pairs_seen == 5'd0) begin
      start_matched_next = head_data.start_ok;
    end else if (pairs_seen <= 5'd20) begin
      // A mark that fits both targets reads as a one.
      if (head_data.mark_one) begin
        bit_shift_next = bit_shift | (20'd1 << bit_pos);
      end
      if (!good && pairs_seen < first_bad_bit) begin
        first_bad_bit_next = pairs_seen;
      end
    end

    data_pairs = pairs_seen_next - 5'd1;
    ok   = 1'b1;
    bits = 5'd0;
    addr = 13'd0;
    if (pairs_seen_next < 5'd8 || !start_matched_next || first_bad_bit_next <= 5'd7) begin
      ok = 1'b0;
    end else if (data_pairs >= 5'd20 && first_bad_bit_next > 5'd20) begin
      bits = 5'd20;
      addr = bit_shift_next[19:7];
    end else if (data_pairs >= 5'd15 && first_bad_bit_next > 5'd15) begin
      bits = 5'd15;
      addr = {5'd0, bit_shift_next[14:7]};
    end else if (data_pairs >= 5'd12) begin
      if (first_bad_bit_next > 5'd12) begin
        bits = 5'd12;
        addr = {8'd0, bit_shift_next[11:7]};
      end else begin
        ok = 1'b0;
      end
    end else begin
      // Seven to eleven data pairs whose first seven are good decode as a 12-bit frame, address zero.
      bits = 5'd12;
    end

    cmd     = bit_shift_next[6:0];
    logical = {addr, cmd};
    raw     = 20'd0;
    case (bits)
      5'd20: begin
        for (int i = 0; i < 20; i++) raw[19-i] = logical[i];
      end
      5'd15: begin
        for (int i = 0; i < 15; i++) raw[14-i] = logical[i];
      end
      5'd12: begin
        for (int i = 0; i < 12; i++) raw[11-i] = logical[i];
      end
      default: raw = 20'd0;
    endcase

    result_next.frame_ok       = ok;
    result_next.command_code   = ok ? cmd  : 7'd0;
    result_next.device_address = ok ? addr : 13'd0;
    result_next.frame_bits     = ok ? bits : 5'd0;
    result_next.wire_raw       = ok ? raw  : 20'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pairs_seen    <= 5'd0;
      start_matched <= 1'b0;
      bit_shift     <= 20'd0;
      first_bad_bit <= sfd_pkg::NoneBad;
      result_valid  <= 1'b0;
    end else begin
      if (pop) begin
        if (head_data.last_pair) begin
          pairs_seen    <= 5'd0;
          start_matched <= 1'b0;
          bit_shift     <= 20'd0;
          first_bad_bit <= sfd_pkg::NoneBad;
        end else begin
          pairs_seen    <= pairs_seen_next;
          start_matched <= start_matched_next;
          bit_shift     <= bit_shift_next;
          first_bad_bit <= first_bad_bit_next;
        end
      end
      if (pop && head_data.last_pair) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_data.last_pair) begin
      result_data <= result_next;
    end
  end

endmodule

// ===== sv/sfd_checker.sv =====
`include "sirc_frame_decoder_top_defines.svh"

module sfd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_we,
  input logic [sfd_pkg::CfgIdxBits-1:0] cfg_index,
  input logic [sfd_pkg::DurBits-1:0]    cfg_data,
  input logic                           pair_valid,
  input logic                           pair_stall,
  input sfd_pkg::pair_t                 pair_data,
  input logic                           result_valid,
  input logic                           result_stall,
  input sfd_pkg::result_t               result_data
);

  // A rejected frame carries all-zero fields.
  `SFD_ASSERT(a_reject_zero, (result_valid && !result_data.frame_ok) |-> (result_data.command_code == 7'd0 && result_data.device_address == 13'd0 && result_data.frame_bits == 5'd0 && result_data.wire_raw == 20'd0), "rejected frame has nonzero fields")

  // A decoded frame has one of the three legal widths.
  `SFD_ASSERT(a_width_legal, (result_valid && result_data.frame_ok) |-> (result_data.frame_bits == 5'd20 || result_data.frame_bits == 5'd15 || result_data.frame_bits == 5'd12), "decoded frame width illegal")

  // Only the 20-bit form uses the upper address bits and the upper raw bits.
  `SFD_ASSERT(a_narrow_fields, (result_valid && result_data.frame_bits != 5'd20) |-> (result_data.device_address[12:8] == 5'd0 && result_data.wire_raw[19:15] == 5'd0), "narrow frame uses wide bits")

  // A stalled result beat stays offered and unchanged.
  `SFD_ASSERT(a_result_hold, (result_valid && result_stall) |=> (result_valid && $stable(result_data)), "stalled result beat changed")

  // No result beat follows a reset cycle.
  `SFD_ASSERT_ALWAYS(a_reset_quiet, rst |=> !result_valid, "result beat after reset")

endmodule

bind sirc_frame_decoder_top sfd_checker u_sfd_checker (.*);
